@@ src/sfr_pkg.sv @@
// Shared types and constants for the SBUS frame receiver.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	localparam int FRAME_BYTES   = 25;
	localparam int CHANNELS      = 16;
	localparam int ADDR_W        = $clog2(FRAME_BYTES);
	localparam int CH_W          = $clog2(CHANNELS);
	localparam int CH_BITS       = 11;
	localparam int OFFSET_CHS    = 4;
	localparam int ACC_W         = CH_BITS + 7;
	localparam int BITS_W        = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;

	localparam logic [ADDR_W-1:0] FIRST_PAYLOAD = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] LAST_PAYLOAD  = ADDR_W'(22);
	localparam logic [ADDR_W-1:0] FLAGS_BYTE    = ADDR_W'(23);
	localparam logic [ADDR_W-1:0] TAIL_BYTE     = ADDR_W'(FRAME_BYTES - 1);
	localparam logic [11:0]       CH_OFFSET     = 12'd1024;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TAIL_CHECK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_VALUE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_VALUE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd3;

	typedef struct packed {
		logic       tail_check;
		logic [7:0] tail_value;
		logic [7:0] head_value;
		logic [7:0] timeout_ticks;
	} sfr_cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} sfr_wr_t;

	typedef struct packed {
		logic       start;
		logic       good;
		logic [7:0] flags;
	} sfr_run_t;

endpackage

`default_nettype wire

@@ src/sfr_store.sv @@
// Frame byte memory: one write port, one read port with registered data.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_store
	import sfr_pkg::*;
(
	input  wire logic              clk,
	input  wire sfr_wr_t           wr,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [7:0]        rd_data
);

	logic [7:0] mem [FRAME_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ src/sfr_framer.sv @@
// Frame hunting, byte collection, frame checks and silence counting.
// Writes bytes into sfr_store and launches result runs. Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_framer
	import sfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sfr_cfg_t   cfg,
	input  wire logic       accept,
	input  wire logic       opcode,
	input  wire logic [7:0] rx_byte,
	output sfr_wr_t         wr,
	output sfr_run_t        run
);

	logic              in_frame_q;
	logic [ADDR_W-1:0] byte_count_q;
	logic [8:0]        silence_q;
	logic [7:0]        head_byte_q;
	logic [7:0]        flags_q;

	logic              in_frame_d;
	logic [ADDR_W-1:0] byte_count_d;
	logic [8:0]        silence_d;
	logic [8:0]        silence_inc;
	logic [8:0]        timeout_ext;

	assign timeout_ext = {1'b0, cfg.timeout_ticks};
	assign silence_inc = silence_q + 9'd1;

	always_comb begin
		in_frame_d   = in_frame_q;
		byte_count_d = byte_count_q;
		silence_d    = silence_q;
		wr.we        = 1'b0;
		wr.addr      = byte_count_q;
		wr.data      = rx_byte;
		run.start    = 1'b0;
		run.good     = 1'b0;
		run.flags    = flags_q;
		if (accept) begin
			if (opcode == OP_TICK) begin
				// saturate one above the timeout
				if (silence_q <= timeout_ext) begin
					silence_d = silence_inc;
					if (silence_inc > timeout_ext) begin
						run.start = 1'b1;
					end
				end
			end else if (!in_frame_q) begin
				if (rx_byte == cfg.head_value) begin
					wr.we        = 1'b1;
					wr.addr      = '0;
					byte_count_d = ADDR_W'(1);
					in_frame_d   = 1'b1;
				end
			end else if (byte_count_q > TAIL_BYTE) begin
				byte_count_d = '0;
				in_frame_d   = 1'b0;
			end else begin
				wr.we        = 1'b1;
				byte_count_d = byte_count_q + ADDR_W'(1);
				if (byte_count_q == TAIL_BYTE) begin
					byte_count_d = '0;
					in_frame_d   = 1'b0;
					if (head_byte_q == cfg.head_value &&
					    (!cfg.tail_check || rx_byte == cfg.tail_value)) begin
						silence_d = '0;
						run.start = 1'b1;
						run.good  = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			byte_count_q <= '0;
			silence_q    <= '0;
		end else begin
			in_frame_q   <= in_frame_d;
			byte_count_q <= byte_count_d;
			silence_q    <= silence_d;
		end
	end

	// keep byte 0 and the flags byte beside the memory for the checks and the run
	always_ff @(posedge clk) begin
		if (wr.we && wr.addr == '0) begin
			head_byte_q <= rx_byte;
		end
		if (wr.we && wr.addr == FLAGS_BYTE) begin
			flags_q <= rx_byte;
		end
	end

endmodule

`default_nettype wire

@@ src/sfr_unpack.sv @@
// Channel unpacker: reads payload bytes from sfr_store into a bit
// accumulator and emits 11-bit channels through an output register.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_unpack
	import sfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfr_run_t          run,
	output logic                   busy,
	output logic                   rd_en,
	output logic      [ADDR_W-1:0] rd_addr,
	input  wire logic [7:0]        rd_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [CH_W-1:0]   channel,
	output logic signed [11:0]     value,
	output logic      [7:0]        flags,
	output logic                   connected,
	output logic                   last
);

	logic              run_q;
	logic              good_q;
	logic [7:0]        flags_q;
	logic [CH_W-1:0]   ch_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              pend_q;
	logic [ACC_W-1:0]  acc_q;
	logic [BITS_W-1:0] bits_q;

	logic              out_valid_q;
	logic [CH_W-1:0]   channel_q;
	logic [11:0]       value_q;
	logic [7:0]        flags_out_q;
	logic              connected_q;
	logic              last_q;

	logic              out_free;
	logic [ACC_W-1:0]  acc_in;
	logic [BITS_W-1:0] bits_in;
	logic [BITS_W-1:0] bits_left;
	logic              emit;
	logic [11:0]       raw_ext;
	logic [11:0]       ch_value;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		acc_in  = acc_q;
		bits_in = bits_q;
		if (pend_q) begin
			acc_in  = acc_q | (ACC_W'(rd_data) << bits_q[3:0]);
			bits_in = bits_q + BITS_W'(8);
		end
		emit      = run_q && out_free && (!good_q || bits_in >= BITS_W'(CH_BITS));
		bits_left = emit ? bits_in - BITS_W'(CH_BITS) : bits_in;
		rd_en     = run_q && good_q && rd_addr_q <= LAST_PAYLOAD
		            && bits_left < BITS_W'(CH_BITS);
		rd_addr   = rd_addr_q;
		raw_ext   = {1'b0, acc_in[CH_BITS-1:0]};
		if (!good_q) begin
			ch_value = '0;
		end else if (ch_q < CH_W'(OFFSET_CHS)) begin
			ch_value = raw_ext - CH_OFFSET;
		end else begin
			ch_value = raw_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (run.start) begin
				run_q  <= 1'b1;
				pend_q <= 1'b0;
			end else begin
				pend_q <= rd_en;
				if (emit && ch_q == CH_W'(CHANNELS - 1)) begin
					run_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run.start) begin
			good_q    <= run.good;
			flags_q   <= run.flags;
			ch_q      <= '0;
			rd_addr_q <= FIRST_PAYLOAD;
			acc_q     <= '0;
			bits_q    <= '0;
		end else begin
			if (rd_en) begin
				rd_addr_q <= rd_addr_q + ADDR_W'(1);
			end
			acc_q  <= emit ? (acc_in >> CH_BITS) : acc_in;
			bits_q <= bits_left;
			if (emit) begin
				ch_q <= ch_q + CH_W'(1);
			end
		end
		if (emit) begin
			channel_q   <= ch_q;
			value_q     <= ch_value;
			flags_out_q <= good_q ? flags_q : 8'd0;
			connected_q <= good_q;
			last_q      <= (ch_q == CH_W'(CHANNELS - 1));
		end
	end

	assign busy      = run_q;
	assign out_valid = out_valid_q;
	assign channel   = channel_q;
	assign value     = $signed(value_q);
	assign flags     = flags_out_q;
	assign connected = connected_q;
	assign last      = last_q;

endmodule

`default_nettype wire

@@ src/sbus_frame_receiver_core.sv @@
// SBUS frame receiver top level: configuration registers and the glue
// between framer, frame memory and unpacker. Depends on sfr_pkg and submodules.
//
// Usage:
//   Input channel (in_valid/in_ready, opcode, rx_byte) takes one word per
//   cycle: a received byte (opcode 0) or a millisecond tick (opcode 1).
//   Bytes that cause no result are taken back to back, one per cycle.
//   An accepted frame (25th byte) or the tick that crosses the timeout starts
//   a run of 16 result words on the output channel (out_valid/out_ready).
//   A frame run reads payload bytes from the frame memory into a bit
//   accumulator, reading the next byte while fewer than 11 bits would be
//   left after an emit. A failsafe run needs no reads and gives one word
//   per cycle while the output register is free.
//   in_ready is low while a run is in progress, so the memory is never
//   written while it is being read; it rises again once the last word of the
//   run sits in the output register, even if that word has not been taken.
//   A stall on out_ready holds the output register and pauses the run.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   indexes beyond the register list are ignored.
//   Reset clears framing, the silence counter and any run, and loads the
//   register defaults; the frame memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sbus_frame_receiver_core
	import sfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  opcode,
	input  wire logic [7:0]            rx_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [CH_W-1:0]       channel,
	output logic signed [11:0]         value,
	output logic      [7:0]            flags,
	output logic                       connected,
	output logic                       last
);

	sfr_cfg_t          cfg_q;
	sfr_wr_t           wr;
	sfr_run_t          run;
	logic              busy;
	logic              accept;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tail_check    <= 1'b1;
			cfg_q.tail_value    <= 8'h00;
			cfg_q.head_value    <= 8'h0F;
			cfg_q.timeout_ticks <= 8'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAIL_CHECK: cfg_q.tail_check    <= cfg_data[0];
				REG_TAIL_VALUE: cfg_q.tail_value    <= cfg_data;
				REG_HEAD_VALUE: cfg_q.head_value    <= cfg_data;
				REG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	sfr_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.opcode  (opcode),
		.rx_byte (rx_byte),
		.wr      (wr),
		.run     (run)
	);

	sfr_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sfr_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.channel   (channel),
		.value     (value),
		.flags     (flags),
		.connected (connected),
		.last      (last)
	);

endmodule

`default_nettype wire

@@ dv/sbus_frame_checker.sv @@
`timescale 1ns / 1ps
// Channel word checker for the SBUS frame receiver: tracks framing, silence
// and register writes, predicts each channel word and compares the output.
// Depends on sfr_pkg only.

module sbus_frame_checker
	import sfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic                  opcode,
	input  wire logic [7:0]            rx_byte,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [CH_W-1:0]       channel,
	input  wire logic [11:0]           value,
	input  wire logic [7:0]            flags,
	input  wire logic                  connected,
	input  wire logic                  last,
	output int                         fail_count,
	output int                         pending_words,
	output int                         frames_decoded,
	output int                         failsafe_runs,
	output int                         words_checked
);

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic [11:0]     val;
		logic [7:0]      flg;
		logic            conn;
		logic            lst;
	} chan_word_t;

	chan_word_t expected_channels[$];

	sfr_cfg_t    regs;
	logic        in_frame;
	logic [4:0]  byte_count;
	logic [7:0]  frame_bytes [FRAME_BYTES];
	logic [8:0]  silence_ticks;

	int mismatches = 0;
	int good_runs  = 0;
	int safe_runs  = 0;
	int compared   = 0;

	assign fail_count     = mismatches;
	assign frames_decoded = good_runs;
	assign failsafe_runs  = safe_runs;
	assign words_checked  = compared;

	// Queue the 16 words of one run: decoded channels, or the failsafe zeros.
	function automatic void queue_run(input logic good);
		logic [8*22-1:0] payload;
		logic [10:0]     raw;
		chan_word_t      w;
		for (int i = 0; i < 22; i++)
			payload[8*i +: 8] = frame_bytes[int'(FIRST_PAYLOAD) + i];
		for (int k = 0; k < CHANNELS; k++) begin
			w.ch = CH_W'(k);
			raw = payload[CH_BITS*k +: CH_BITS];
			if (good)
				w.val = {1'b0, raw} - ((k < OFFSET_CHS) ? CH_OFFSET : 12'd0);
			else
				w.val = 12'd0;
			w.flg = good ? frame_bytes[FLAGS_BYTE] : 8'h00;
			w.conn = good;
			w.lst = (k == CHANNELS - 1);
			expected_channels.push_back(w);
		end
		if (good)
			good_runs++;
		else
			safe_runs++;
	endfunction

	function automatic void track_input(input logic op, input logic [7:0] b);
		if (op == OP_TICK) begin
			// saturate one above the timeout; the crossing tick fires failsafe
			if (silence_ticks <= {1'b0, regs.timeout_ticks}) begin
				silence_ticks = silence_ticks + 9'd1;
				if (silence_ticks > {1'b0, regs.timeout_ticks})
					queue_run(1'b0);
			end
		end else if (!in_frame) begin
			if (b == regs.head_value) begin
				frame_bytes[0] = b;
				byte_count = 5'd1;
				in_frame = 1'b1;
			end
		end else begin
			frame_bytes[byte_count] = b;
			byte_count = byte_count + 5'd1;
			if (int'(byte_count) == FRAME_BYTES) begin
				byte_count = 5'd0;
				in_frame = 1'b0;
				if (frame_bytes[0] == regs.head_value &&
				    (!regs.tail_check || frame_bytes[TAIL_BYTE] == regs.tail_value)) begin
					silence_ticks = 9'd0;
					queue_run(1'b1);
				end
			end
		end
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
	                                       input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_TAIL_CHECK: regs.tail_check = data[0];
			REG_TAIL_VALUE: regs.tail_value = data;
			REG_HEAD_VALUE: regs.head_value = data;
			REG_TIMEOUT:    regs.timeout_ticks = data;
			default: ;
		endcase
	endfunction

	function automatic bit report_field(input string name, input int want, input int got,
	                                    input bit differs);
		if (differs)
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		return differs;
	endfunction

	function automatic void check_channel_word();
		chan_word_t want;
		bit bad;
		if (expected_channels.size() == 0) begin
			$display("%0t: unexpected channel word, expected none actual ch %0d value %0d",
			         $time, channel, $signed(value));
			mismatches++;
			return;
		end
		want = expected_channels.pop_front();
		bad = 1'b0;
		bad |= report_field("channel", want.ch, channel, channel !== want.ch);
		bad |= report_field("value", int'($signed(want.val)), int'($signed(value)),
		                    value !== want.val);
		bad |= report_field("flags", want.flg, flags, flags !== want.flg);
		bad |= report_field("connected", want.conn, connected, connected !== want.conn);
		bad |= report_field("last", want.lst, last, last !== want.lst);
		if (bad)
			mismatches++;
		compared++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.tail_check = 1'b1;
			regs.tail_value = 8'h00;
			regs.head_value = 8'h0F;
			regs.timeout_ticks = 8'd60;
			in_frame = 1'b0;
			byte_count = 5'd0;
			silence_ticks = 9'd0;
			expected_channels.delete();
			pending_words <= 0;
		end else begin
			if (out_valid && out_ready)
				check_channel_word();
			if (in_valid && in_ready)
				track_input(opcode, rx_byte);
			if (cfg_we)
				apply_register(cfg_index, cfg_data);
			pending_words <= expected_channels.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the SBUS frame receiver test: clock, reset, register writes, byte and
// tick traffic with bursty input and stalling output; needs sfr_pkg, the block
// and sbus_frame_checker.

module testbench;
	import sfr_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_WORDS  = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int FILL_RANDOM  = 0;
	localparam int FILL_EXTREME = 1;

	localparam int RDY_ALWAYS = 0;
	localparam int RDY_RANDOM = 1;
	localparam int RDY_SPARSE = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  opcode;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [CH_W-1:0]       channel;
	logic signed [11:0]    value;
	logic [7:0]            flags;
	logic                  connected;
	logic                  last;

	int fail_count;
	int pending_words;
	int frames_decoded;
	int failsafe_runs;
	int words_checked;

	int   words_sent   = 0;
	int   burst_left   = 0;
	int   idle_cycles  = 0;
	bit   hold_off_req = 1'b0;
	logic [7:0] cur_head    = 8'h0F;
	logic [7:0] cur_tail    = 8'h00;
	logic [7:0] cur_timeout = 8'd60;

	sbus_frame_receiver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.channel   (channel),
		.value     (value),
		.flags     (flags),
		.connected (connected),
		.last      (last)
	);

	sbus_frame_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.channel        (channel),
		.value          (value),
		.flags          (flags),
		.connected      (connected),
		.last           (last),
		.fail_count     (fail_count),
		.pending_words  (pending_words),
		.frames_decoded (frames_decoded),
		.failsafe_runs  (failsafe_runs),
		.words_checked  (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Output stalls: segments of always-ready, coin-flip and sparse ready,
	// plus one long hold-off on request.
	initial begin : receiver
		int seg_len;
		int seg_mode;
		int n;
		out_ready = 1'b0;
		forever begin
			seg_len = $urandom_range(5, 60);
			seg_mode = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
			for (n = 0; n < seg_len; n++) begin
				@(negedge clk);
				if (hold_off_req) begin
					hold_off_req = 1'b0;
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (seg_mode)
					RDY_ALWAYS: out_ready <= 1'b1;
					RDY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
					default:    out_ready <= (n % 4 == 0);
				endcase
			end
		end
	end

	// Offer one word in the current burst; open a random gap between bursts.
	task automatic send_word(input logic op, input logic [7:0] b, input bit counted);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (counted)
			words_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_word(OP_TICK, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			do b = 8'($urandom_range(0, 255)); while (b == cur_head);
			send_word(OP_BYTE, b, 1'b0);
		end
	endtask

	// Extreme fill: low payload half all zeros, high half and flags all ones.
	task automatic send_frame(input int fill, input bit good_tail, input bit with_ticks);
		logic [7:0] frame [FRAME_BYTES];
		frame[0] = cur_head;
		for (int i = 1; i < FRAME_BYTES - 1; i++)
			if (fill == FILL_EXTREME)
				frame[i] = (i <= 11) ? 8'h00 : 8'hFF;
			else
				frame[i] = 8'($urandom_range(0, 255));
		frame[TAIL_BYTE] = good_tail ? cur_tail : cur_tail ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (with_ticks && i > 0 && $urandom_range(0, 7) == 0)
				send_ticks(1);
			send_word(OP_BYTE, frame[i], 1'b1);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] check_data, input logic [7:0] tail,
	                          input logic [7:0] head, input logic [7:0] timeout);
		write_reg(REG_TAIL_CHECK, check_data);
		write_reg(REG_TAIL_VALUE, tail);
		write_reg(REG_HEAD_VALUE, head);
		write_reg(REG_TIMEOUT, timeout);
		cur_tail = tail;
		cur_head = head;
		cur_timeout = timeout;
	endtask

	// Drop valid, drain every expected word, then give the block time to go idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content; the rest is bad tails,
	// tick bursts and stray bytes.
	task automatic random_traffic(input int count);
		int stop_at;
		int pick;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				send_frame(FILL_RANDOM, 1'b1, pick < 2);
			else if (pick == 6)
				send_frame(FILL_RANDOM, 1'b0, 1'b1);
			else if (pick < 9)
				send_ticks((cur_timeout <= 8) ? $urandom_range(1, cur_timeout + 3)
				                              : $urandom_range(1, 6));
			else
				send_noise($urandom_range(1, 4));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_BYTE;
		rx_byte = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, bad tail, failsafe and saturation at reset framing
		write_reg(REG_SPARE_LO, 8'hA5);
		write_reg(REG_TIMEOUT, 8'd3);
		cur_timeout = 8'd3;
		send_frame(FILL_EXTREME, 1'b1, 1'b0);
		send_frame(FILL_RANDOM, 1'b0, 1'b0);
		send_ticks(6);
		settle();

		// lower the timeout below the silence count: no failsafe until a frame
		write_reg(REG_TIMEOUT, 8'd10);
		cur_timeout = 8'd10;
		send_frame(FILL_RANDOM, 1'b1, 1'b0);
		send_ticks(5);
		settle();
		write_reg(REG_TIMEOUT, 8'd2);
		cur_timeout = 8'd2;
		send_ticks(3);
		send_frame(FILL_RANDOM, 1'b1, 1'b0);
		send_ticks(3);
		settle();

		// tail check off via a write with the upper bits set; long output hold
		set_config(8'hFE, 8'hFF, 8'h00, 8'd1);
		hold_off_req = 1'b1;
		send_frame(FILL_RANDOM, 1'b1, 1'b0);
		random_traffic(PHASE_WORDS);
		settle();

		set_config(8'h01, 8'hFF, 8'hFF, 8'd255);
		write_reg(REG_SPARE_HI, 8'h5A);
		random_traffic(PHASE_WORDS);
		settle();

		set_config(8'h01, 8'h00, 8'h0F, 8'($urandom_range(2, 4)));
		random_traffic(PHASE_WORDS);
		settle();

		set_config(8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
		           8'($urandom_range(1, 6)));
		random_traffic(PHASE_WORDS);
		settle();

		$display("Sent %0d bytes and ticks over five register settings;", words_sent);
		$display("checked %0d channel words from %0d frames and %0d failsafe runs.",
		         words_checked, frames_decoded, failsafe_runs);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
src/sfr_pkg.sv
src/sfr_store.sv
src/sfr_framer.sv
src/sfr_unpack.sv
src/sbus_frame_receiver_core.sv
dv/sbus_frame_checker.sv
dv/testbench.sv
